// ===== rtl/dae_pkg.sv =====
// Package for the distance-to-acceleration estimator.
// Holds the sequencer program, its control word types and the datapath constants.
// Depends on nothing.
package dae_pkg;

   localparam int DAE_WINDOW = 5;

   // Divider dividend width and the iteration counts of the two time divisions.
   localparam int DIV_W = 42;
   localparam int K_DX  = 36;
   localparam int K_DV  = 42;

   localparam logic [15:0] MIN_INTERVAL_RST = 16'd100;
   localparam logic [19:0] STILL_THR_RST    = 20'd500;
   localparam logic [30:0] ACCEL_LIMIT_RST  = 31'd20000000;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_MIN_INTERVAL = 2'd0;
   localparam csr_index_type CSR_STILL_THR    = 2'd1;
   localparam csr_index_type CSR_ACCEL_LIMIT  = 2'd2;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_TAKE,
      OP_RING,
      OP_LOAD_POS,
      OP_DIV,
      OP_SET_X,
      OP_LOAD_DX,
      OP_SET_V,
      OP_LOAD_DV,
      OP_SET_A,
      OP_EMIT,
      OP_FIRST,
      OP_STILL,
      OP_SCALE
   } op_type;

   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_SKIP,
      C_DIV_MORE,
      C_NOT_STARTED,
      C_STILL,
      C_OUT_BUSY
   } cond_type;

   typedef logic [3:0] step_type;

   localparam step_type STEP_IDLE    = 4'd0;
   localparam step_type STEP_CHECK   = 4'd1;
   localparam step_type STEP_RING    = 4'd2;
   localparam step_type STEP_LDPOS   = 4'd3;
   localparam step_type STEP_SCALE   = 4'd4;
   localparam step_type STEP_SETX    = 4'd5;
   localparam step_type STEP_LDDX    = 4'd6;
   localparam step_type STEP_DIVDX   = 4'd7;
   localparam step_type STEP_SETV    = 4'd8;
   localparam step_type STEP_LDDV    = 4'd9;
   localparam step_type STEP_DIVDV   = 4'd10;
   localparam step_type STEP_SETA    = 4'd11;
   localparam step_type STEP_EMIT    = 4'd12;
   localparam step_type STEP_DONE    = 4'd13;
   localparam step_type STEP_FIRST   = 4'd14;
   localparam step_type STEP_STILL   = 4'd15;

   localparam int STEPS = 16;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } uword_type;

   // A step jumps to its target when its condition holds, else it goes on to the next step.
   localparam uword_type UCODE [STEPS] = '{
      '{OP_TAKE,     C_NO_REQ,      STEP_IDLE},
      '{OP_NOP,      C_SKIP,        STEP_IDLE},
      '{OP_RING,     C_NEVER,       STEP_IDLE},
      '{OP_LOAD_POS, C_NEVER,       STEP_IDLE},
      '{OP_SCALE,    C_NEVER,       STEP_IDLE},
      '{OP_SET_X,    C_NOT_STARTED, STEP_FIRST},
      '{OP_LOAD_DX,  C_STILL,       STEP_STILL},
      '{OP_DIV,      C_DIV_MORE,    STEP_DIVDX},
      '{OP_SET_V,    C_NEVER,       STEP_IDLE},
      '{OP_LOAD_DV,  C_NEVER,       STEP_IDLE},
      '{OP_DIV,      C_DIV_MORE,    STEP_DIVDV},
      '{OP_SET_A,    C_NEVER,       STEP_IDLE},
      '{OP_EMIT,     C_OUT_BUSY,    STEP_EMIT},
      '{OP_NOP,      C_ALWAYS,      STEP_IDLE},
      '{OP_FIRST,    C_ALWAYS,      STEP_IDLE},
      '{OP_STILL,    C_ALWAYS,      STEP_IDLE}
   };

   // Multiplication by 1000 as shifts and subtractions.
   function automatic logic [DIV_W-1:0] times_1000(input logic [DIV_W-1:0] a);
      times_1000 = (a << 10) - (a << 4) - (a << 3);
   endfunction

endpackage

// ===== rtl/distance_to_accel_estimator_core.sv =====
// Top level of the distance-to-acceleration estimator.
// A microcoded sequencer over a datapath with one shared restoring divider.
// Depends on dae_pkg.

// Each accepted item runs through the microcode steps until the sequencer is idle again.
// An ignored item (zero distance or too soon after the last accepted one) goes back to
// idle from the check step; a first sample ends in the first-sample step and a
// standing-still sample in the still step. The window mean is a constant reciprocal
// multiplication in one step. A moving sample also runs the two time divisions on the
// shared one-bit-per-cycle divider, 36 quotient bits for velocity and 42 for acceleration.
// The block accepts an item only when its sequencer is idle; a finished result waits in
// the output register, and the sequencer stalls at the output step only while an earlier
// result has not yet been taken. Configuration writes take effect at once and are meant to
// be made while no item is in work.
module distance_to_accel_estimator_core #(
   parameter int WINDOW = dae_pkg::DAE_WINDOW
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_time_ms,
   input  logic [15:0]        req_distance_mm,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [25:0]        rsp_position_um,
   output logic signed [31:0] rsp_velocity_um_s,
   output logic signed [31:0] rsp_accel_um_s2,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [30:0]        csr_wdata
);

   localparam int DIV_W = dae_pkg::DIV_W;
   localparam int SUM_W = $clog2(WINDOW * 65535 + 1);
   localparam int K_POS = SUM_W + 10;
   localparam int CNT_W = $clog2(DIV_W + 1);
   localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   // Division by WINDOW as a multiplication by a rounded-up reciprocal, which is exact
   // for every dividend below 2**K_POS.
   localparam int     RCP_SH = K_POS + $clog2(WINDOW);
   localparam longint RCP_M  = ((longint'(1) << RCP_SH) + longint'(WINDOW) - 1) /
                               longint'(WINDOW);
   localparam int     PROD_W = 2 * K_POS + 1;

   // Control state
   dae_pkg::step_type pc_ff, pc_in;
   logic              started_ff, started_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [15:0]       ring_ff [WINDOW];
   logic [15:0]       ring_in [WINDOW];
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [31:0]       last_ff, last_in;
   logic [31:0]       ref_time_ff, ref_time_in;
   logic [25:0]       ref_pos_ff, ref_pos_in;
   logic signed [31:0] ref_vel_ff, ref_vel_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       min_int_ff, min_int_in;
   logic [19:0]       still_thr_ff, still_thr_in;
   logic [30:0]       acc_lim_ff, acc_lim_in;

   // Datapath registers
   logic [31:0]        t_ff, t_in;
   logic [15:0]        d_ff, d_in;
   logic [DIV_W-1:0]   q_ff, q_in;
   logic [31:0]        rem_ff, rem_in;
   logic [31:0]        div_ff, div_in;
   logic               neg_ff, neg_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [25:0]        x_ff, x_in;
   logic signed [31:0] v_ff, v_in;
   logic signed [31:0] a_ff, a_in;
   logic [25:0]        out_pos_ff, out_pos_in;
   logic signed [31:0] out_vel_ff, out_vel_in;
   logic signed [31:0] out_acc_ff, out_acc_in;

   dae_pkg::uword_type uw;
   logic               jump;
   logic               out_free;
   logic               skip;
   logic               still;
   logic signed [26:0] dx;
   logic [25:0]        adx;
   logic [31:0]        dt;
   logic [31:0]        ref_dt;
   logic signed [32:0] dv;
   logic [32:0]        adv;
   logic [32:0]        trial;
   logic [32:0]        diff;
   logic               ge;
   logic [PROD_W-1:0]  pos_prod;
   logic signed [DIV_W:0] qs;
   logic signed [DIV_W:0] lim_s;
   logic signed [DIV_W:0] max32;
   logic signed [DIV_W:0] min32;

   assign uw        = dae_pkg::UCODE[pc_ff];
   assign req_ready = (pc_ff == dae_pkg::STEP_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_position_um   = out_pos_ff;
   assign rsp_velocity_um_s = out_vel_ff;
   assign rsp_accel_um_s2   = out_acc_ff;

   always_comb begin
      // Shared arithmetic
      dt       = t_ff - last_ff;
      skip     = (d_ff == 16'd0) || (dt < {16'd0, min_int_ff});
      dx       = $signed({1'b0, x_ff}) - $signed({1'b0, ref_pos_ff});
      adx      = 26'(dx[26] ? -dx : dx);
      still    = adx < 26'(still_thr_ff);
      ref_dt   = t_ff - ref_time_ff;
      dv       = $signed({v_ff[31], v_ff}) - $signed({ref_vel_ff[31], ref_vel_ff});
      adv      = dv[32] ? 33'(-dv) : 33'(dv);
      trial    = {rem_ff, q_ff[DIV_W-1]};
      diff     = trial - {1'b0, div_ff};
      ge       = trial >= {1'b0, div_ff};
      pos_prod = PROD_W'(q_ff[K_POS-1:0]) * PROD_W'(RCP_M);
      qs       = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
      lim_s    = $signed({{(DIV_W - 30){1'b0}}, acc_lim_ff});
      max32    = $signed({{(DIV_W - 30){1'b0}}, {31{1'b1}}});
      min32    = $signed({{(DIV_W - 31){1'b1}}, 1'b1, 31'd0});

      case (uw.cond)
         dae_pkg::C_NEVER:       jump = 1'b0;
         dae_pkg::C_ALWAYS:      jump = 1'b1;
         dae_pkg::C_NO_REQ:      jump = !req_valid;
         dae_pkg::C_SKIP:        jump = skip;
         dae_pkg::C_DIV_MORE:    jump = (cnt_ff != CNT_W'(1));
         dae_pkg::C_NOT_STARTED: jump = !started_ff;
         dae_pkg::C_STILL:       jump = still;
         dae_pkg::C_OUT_BUSY:    jump = !out_free;
         default:                jump = 1'b0;
      endcase
      pc_in = jump ? uw.target : dae_pkg::step_type'(pc_ff + 4'd1);

      started_in   = started_ff;
      ptr_in       = ptr_ff;
      ring_in      = ring_ff;
      sum_in       = sum_ff;
      last_in      = last_ff;
      ref_time_in  = ref_time_ff;
      ref_pos_in   = ref_pos_ff;
      ref_vel_in   = ref_vel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      t_in         = t_ff;
      d_in         = d_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      x_in         = x_ff;
      v_in         = v_ff;
      a_in         = a_ff;
      out_pos_in   = out_pos_ff;
      out_vel_in   = out_vel_ff;
      out_acc_in   = out_acc_ff;

      case (uw.op)
         dae_pkg::OP_NOP: begin
         end
         dae_pkg::OP_TAKE: begin
            if (req_valid) begin
               t_in = req_time_ms;
               d_in = req_distance_mm;
            end
         end
         dae_pkg::OP_RING: begin
            // The running sum replaces the oldest sample by the new one.
            ring_in[ptr_ff] = d_ff;
            sum_in = sum_ff - SUM_W'(ring_ff[ptr_ff]) + SUM_W'(d_ff);
            ptr_in = (ptr_ff == PTR_W'(WINDOW - 1)) ? '0 : PTR_W'(ptr_ff + 1'b1);
         end
         dae_pkg::OP_LOAD_POS: begin
            q_in = dae_pkg::times_1000(DIV_W'(sum_ff));
         end
         dae_pkg::OP_SCALE: begin
            q_in = DIV_W'(pos_prod >> RCP_SH);
         end
         dae_pkg::OP_DIV: begin
            rem_in = ge ? diff[31:0] : trial[31:0];
            q_in   = {q_ff[DIV_W-2:0], ge};
            cnt_in = CNT_W'(cnt_ff - 1'b1);
         end
         dae_pkg::OP_SET_X: begin
            x_in = q_ff[25:0];
         end
         dae_pkg::OP_LOAD_DX: begin
            q_in   = dae_pkg::times_1000(DIV_W'(adx)) << (DIV_W - dae_pkg::K_DX);
            rem_in = '0;
            div_in = (ref_dt == 32'd0) ? 32'd1 : ref_dt;
            neg_in = dx[26];
            cnt_in = CNT_W'(dae_pkg::K_DX);
         end
         dae_pkg::OP_SET_V: begin
            if (qs > max32) begin
               v_in = 32'sh7FFF_FFFF;
            end else if (qs < min32) begin
               v_in = 32'sh8000_0000;
            end else begin
               v_in = qs[31:0];
            end
         end
         dae_pkg::OP_LOAD_DV: begin
            // The divisor from the velocity division is still in place.
            q_in   = dae_pkg::times_1000(DIV_W'(adv)) << (DIV_W - dae_pkg::K_DV);
            rem_in = '0;
            neg_in = dv[32];
            cnt_in = CNT_W'(dae_pkg::K_DV);
         end
         dae_pkg::OP_SET_A: begin
            if (qs > lim_s) begin
               a_in = $signed({1'b0, acc_lim_ff});
            end else if (qs < -lim_s) begin
               a_in = -$signed({1'b0, acc_lim_ff});
            end else begin
               a_in = qs[31:0];
            end
         end
         dae_pkg::OP_EMIT: begin
            if (out_free) begin
               out_pos_in   = x_ff;
               out_vel_in   = v_ff;
               out_acc_in   = a_ff;
               rsp_valid_in = 1'b1;
               ref_time_in  = t_ff;
               ref_pos_in   = x_ff;
               ref_vel_in   = v_ff;
               last_in      = t_ff;
            end
         end
         dae_pkg::OP_FIRST: begin
            started_in  = 1'b1;
            ref_time_in = t_ff;
            ref_pos_in  = x_ff;
            ref_vel_in  = '0;
            last_in     = t_ff;
         end
         dae_pkg::OP_STILL: begin
            ref_vel_in = '0;
            last_in    = t_ff;
         end
         default: begin
         end
      endcase

      min_int_in   = min_int_ff;
      still_thr_in = still_thr_ff;
      acc_lim_in   = acc_lim_ff;
      if (csr_we) begin
         case (csr_index)
            dae_pkg::CSR_MIN_INTERVAL: min_int_in   = csr_wdata[15:0];
            dae_pkg::CSR_STILL_THR:    still_thr_in = csr_wdata[19:0];
            dae_pkg::CSR_ACCEL_LIMIT:  acc_lim_in   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= dae_pkg::STEP_IDLE;
         started_ff   <= 1'b0;
         ptr_ff       <= '0;
         for (int i = 0; i < WINDOW; i++) begin
            ring_ff[i] <= '0;
         end
         sum_ff       <= '0;
         last_ff      <= '0;
         ref_time_ff  <= '0;
         ref_pos_ff   <= '0;
         ref_vel_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         min_int_ff   <= dae_pkg::MIN_INTERVAL_RST;
         still_thr_ff <= dae_pkg::STILL_THR_RST;
         acc_lim_ff   <= dae_pkg::ACCEL_LIMIT_RST;
      end else begin
         pc_ff        <= pc_in;
         started_ff   <= started_in;
         ptr_ff       <= ptr_in;
         ring_ff      <= ring_in;
         sum_ff       <= sum_in;
         last_ff      <= last_in;
         ref_time_ff  <= ref_time_in;
         ref_pos_ff   <= ref_pos_in;
         ref_vel_ff   <= ref_vel_in;
         rsp_valid_ff <= rsp_valid_in;
         min_int_ff   <= min_int_in;
         still_thr_ff <= still_thr_in;
         acc_lim_ff   <= acc_lim_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff       <= t_in;
      d_ff       <= d_in;
      q_ff       <= q_in;
      rem_ff     <= rem_in;
      div_ff     <= div_in;
      neg_ff     <= neg_in;
      cnt_ff     <= cnt_in;
      x_ff       <= x_in;
      v_ff       <= v_in;
      a_ff       <= a_in;
      out_pos_ff <= out_pos_in;
      out_vel_ff <= out_vel_in;
      out_acc_ff <= out_acc_in;
   end

endmodule

// ===== bench/tb_distance_to_accel_estimator_core.sv =====
// Testbench for distance_to_accel_estimator_core: directed rows, then random sample streams.
// Results are checked against a behavioral estimator kept inside this file.
// Depends on dae_pkg and the core RTL.
module tb_distance_to_accel_estimator_core;

   localparam int RING_DEPTH    = dae_pkg::DAE_WINDOW;
   localparam int SETTLE_CYCLES = 150;
   localparam int STALL_LIMIT   = 2000;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 240;

   typedef struct packed {
      logic [25:0]        pos;
      logic signed [31:0] vel;
      logic signed [31:0] acc;
   } motion_type;

   typedef enum logic [1:0] {ROW_SAMPLE, ROW_WRITE} row_kind_type;
   typedef enum logic [1:0] {WANT_MODEL, WANT_NOTHING, WANT_MOTION} row_want_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [31:0]            t;
      logic [15:0]            d;
      dae_pkg::csr_index_type idx;
      logic [30:0]            val;
      row_want_type           want;
      motion_type             m;
   } plan_row_type;

   localparam motion_type NO_MOTION = '0;

   // Opening sequence under the reset register values, then under extreme settings.
   localparam plan_row_type OPENING [26] = '{
      // Too early after reset, then a zero distance: both ignored.
      '{ROW_SAMPLE, 32'd50, 16'd1000, dae_pkg::CSR_MIN_INTERVAL, 31'd0, WANT_NOTHING,
        NO_MOTION},
      '{ROW_SAMPLE, 32'd200, 16'd0, dae_pkg::CSR_MIN_INTERVAL, 31'd0, WANT_NOTHING,
        NO_MOTION},
      // First taken sample only sets the reference; the next one is too soon.
      '{ROW_SAMPLE, 32'd200, 16'd1000, dae_pkg::CSR_MIN_INTERVAL, 31'd0, WANT_NOTHING,
        NO_MOTION},
      '{ROW_SAMPLE, 32'd250, 16'd1000, dae_pkg::CSR_MIN_INTERVAL, 31'd0, WANT_NOTHING,
        NO_MOTION},
      // Partly filled window: two samples of 1000 mm average to 400000 um.
      '{ROW_SAMPLE, 32'd300, 16'd1000, dae_pkg::CSR_MIN_INTERVAL, 31'd0, WANT_MOTION,
        '{26'd400000, 32'sd2000000, 32'sd20000000}},
      '{ROW_SAMPLE, 32'd400, 16'd65535, dae_pkg::CSR_MIN_INTERVAL, 31'd0, WANT_MODEL,
        NO_MOTION},
      '{ROW_SAMPLE, 32'd500, 16'd65535, dae_pkg::CSR_MIN_INTERVAL, 31'd0, WANT_MODEL,
        NO_MOTION},
      '{ROW_SAMPLE, 32'd600, 16'd65535, dae_pkg::CSR_MIN_INTERVAL, 31'd0, WANT_MODEL,
        NO_MOTION},
      '{ROW_SAMPLE, 32'd700, 16'd65535, dae_pkg::CSR_MIN_INTERVAL, 31'd0, WANT_MODEL,
        NO_MOTION},
      '{ROW_SAMPLE, 32'd800, 16'd65535, dae_pkg::CSR_MIN_INTERVAL, 31'd0, WANT_MODEL,
        NO_MOTION},
      // Full window of the largest distance: the position no longer moves.
      '{ROW_SAMPLE, 32'd900, 16'd65535, dae_pkg::CSR_MIN_INTERVAL, 31'd0, WANT_NOTHING,
        NO_MOTION},
      '{ROW_SAMPLE, 32'hFFFF_FFFF, 16'd65535, dae_pkg::CSR_MIN_INTERVAL, 31'd0,
        WANT_NOTHING, NO_MOTION},
      '{ROW_WRITE, 32'd0, 16'd0, dae_pkg::CSR_MIN_INTERVAL, 31'd0, WANT_NOTHING,
        NO_MOTION},
      '{ROW_WRITE, 32'd0, 16'd0, dae_pkg::CSR_STILL_THR, 31'd0, WANT_NOTHING, NO_MOTION},
      '{ROW_SAMPLE, 32'hFFFF_FFFF, 16'd1, dae_pkg::CSR_MIN_INTERVAL, 31'd0, WANT_MODEL,
        NO_MOTION},
      // Same timestamp again: zero elapsed time, velocity saturates low.
      '{ROW_SAMPLE, 32'hFFFF_FFFF, 16'd1, dae_pkg::CSR_MIN_INTERVAL, 31'd0, WANT_MODEL,
        NO_MOTION},
      // Timestamp wraps to zero; the position does not change but the threshold is zero.
      '{ROW_SAMPLE, 32'd0, 16'd65535, dae_pkg::CSR_MIN_INTERVAL, 31'd0, WANT_MODEL,
        NO_MOTION},
      '{ROW_WRITE, 32'd0, 16'd0, dae_pkg::CSR_ACCEL_LIMIT, 31'h7FFF_FFFF, WANT_NOTHING,
        NO_MOTION},
      '{ROW_SAMPLE, 32'd1, 16'd1, dae_pkg::CSR_MIN_INTERVAL, 31'd0, WANT_MODEL,
        NO_MOTION},
      '{ROW_WRITE, 32'd0, 16'd0, dae_pkg::CSR_ACCEL_LIMIT, 31'd0, WANT_NOTHING,
        NO_MOTION},
      '{ROW_SAMPLE, 32'd2, 16'd1, dae_pkg::CSR_MIN_INTERVAL, 31'd0, WANT_MODEL,
        NO_MOTION},
      // Velocity saturates high while acceleration is clamped to zero.
      '{ROW_SAMPLE, 32'd3, 16'd65535, dae_pkg::CSR_MIN_INTERVAL, 31'd0, WANT_MODEL,
        NO_MOTION},
      '{ROW_WRITE, 32'd0, 16'd0, dae_pkg::CSR_STILL_THR, 31'h000F_FFFF, WANT_NOTHING,
        NO_MOTION},
      '{ROW_WRITE, 32'd0, 16'd0, dae_pkg::CSR_MIN_INTERVAL, 31'h0000_FFFF, WANT_NOTHING,
        NO_MOTION},
      '{ROW_SAMPLE, 32'd4, 16'd100, dae_pkg::CSR_MIN_INTERVAL, 31'd0, WANT_NOTHING,
        NO_MOTION},
      '{ROW_SAMPLE, 32'd65538, 16'd60000, dae_pkg::CSR_MIN_INTERVAL, 31'd0, WANT_MODEL,
        NO_MOTION}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [31:0]        req_time_ms = '0;
   logic [15:0]        req_distance_mm = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b1;
   logic [25:0]        rsp_position_um;
   logic signed [31:0] rsp_velocity_um_s;
   logic signed [31:0] rsp_accel_um_s2;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = dae_pkg::CSR_MIN_INTERVAL;
   logic [30:0]        csr_wdata = '0;

   // Estimator state and register copies.
   logic [15:0] ring_mm [RING_DEPTH] = '{default: '0};
   int unsigned ring_slot = 0;
   logic [31:0] last_take_ms = '0;
   logic [31:0] anchor_ms = '0;
   bit          tracking = 1'b0;
   longint      anchor_pos_um = 0;
   longint      anchor_vel = 0;
   logic [15:0] cfg_min_gap = dae_pkg::MIN_INTERVAL_RST;
   logic [19:0] cfg_still = dae_pkg::STILL_THR_RST;
   logic [30:0] cfg_acc_lim = dae_pkg::ACCEL_LIMIT_RST;

   motion_type  motion_q [$];
   bit          quiet_mode = 1'b0;
   int          faults = 0;
   int          results_checked = 0;
   int          fed_items = 0;
   int          taken_items = 0;

   distance_to_accel_estimator_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_time_ms       (req_time_ms),
      .req_distance_mm   (req_distance_mm),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_position_um   (rsp_position_um),
      .rsp_velocity_um_s (rsp_velocity_um_s),
      .rsp_accel_um_s2   (rsp_accel_um_s2),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #10 clock = ~clock;

   // Advances the estimator by one sample; returns 1 when a motion result is due.
   function automatic bit estimate_motion(input logic [31:0] t, input logic [15:0] d,
                                          output motion_type m, output bit taken);
      logic [31:0] elapsed;
      longint      sum, x, dx, adx, span, v, a, lim;
      m = '0;
      taken = 1'b0;
      if (d == 0) return 1'b0;
      elapsed = t - last_take_ms;
      if (elapsed < cfg_min_gap) return 1'b0;
      taken = 1'b1;
      ring_mm[ring_slot] = d;
      ring_slot = (ring_slot + 1) % RING_DEPTH;
      sum = 0;
      foreach (ring_mm[i]) sum += ring_mm[i];
      x = (sum * 1000) / RING_DEPTH;
      last_take_ms = t;
      if (!tracking) begin
         tracking = 1'b1;
         anchor_ms = t;
         anchor_pos_um = x;
         anchor_vel = 0;
         return 1'b0;
      end
      dx = x - anchor_pos_um;
      adx = (dx < 0) ? -dx : dx;
      if (adx < longint'(cfg_still)) begin
         anchor_vel = 0;
         return 1'b0;
      end
      elapsed = t - anchor_ms;
      span = (elapsed == 0) ? 1 : longint'(elapsed);
      v = (dx * 1000) / span;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      a = ((v - anchor_vel) * 1000) / span;
      lim = longint'(cfg_acc_lim);
      if (a > lim) a = lim;
      if (a < -lim) a = -lim;
      anchor_ms = t;
      anchor_pos_um = x;
      anchor_vel = v;
      m.pos = x[25:0];
      m.vel = v[31:0];
      m.acc = a[31:0];
      return 1'b1;
   endfunction

   task automatic send_sample(input logic [31:0] t, input logic [15:0] d,
                              input row_want_type want, input motion_type typed);
      motion_type  m;
      bit          taken, due;
      int unsigned gap;
      gap = quiet_mode ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_time_ms <= t;
      req_distance_mm <= d;
      do @(posedge clock); while (!req_ready);
      due = estimate_motion(t, d, m, taken);
      fed_items++;
      if (taken) taken_items++;
      case (want)
         WANT_MODEL: begin
            if (due) motion_q.push_back(m);
         end
         WANT_MOTION: motion_q.push_back(typed);
         WANT_NOTHING: begin
            if (due) begin
               $display("%0t: sample at %0d ms expected no result, estimator gives one",
                        $time, t);
               faults++;
               motion_q.push_back(m);
            end
         end
         default: ;
      endcase
   endtask

   // Drops valid and waits until every expected result has come, plus extra cycles.
   task automatic drain_results(input int unsigned extra);
      req_valid <= 1'b0;
      do @(posedge clock); while (motion_q.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(input dae_pkg::csr_index_type idx, input logic [30:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         dae_pkg::CSR_MIN_INTERVAL: cfg_min_gap = val[15:0];
         dae_pkg::CSR_STILL_THR:    cfg_still = val[19:0];
         dae_pkg::CSR_ACCEL_LIMIT:  cfg_acc_lim = val;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      logic [31:0] clock_ms;
      logic [15:0] d;
      int          walk;
      int unsigned roll, phase_base;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (OPENING[i]) begin
         if (OPENING[i].kind == ROW_WRITE) begin
            drain_results(SETTLE_CYCLES);
            write_reg(OPENING[i].idx, OPENING[i].val);
         end else begin
            send_sample(OPENING[i].t, OPENING[i].d, OPENING[i].want, OPENING[i].m);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results(SETTLE_CYCLES);
         case ($urandom_range(0, 3))
            0: write_reg(dae_pkg::CSR_MIN_INTERVAL, 31'd0);
            1: write_reg(dae_pkg::CSR_MIN_INTERVAL, 31'h0000_FFFF);
            2: write_reg(dae_pkg::CSR_MIN_INTERVAL, 31'd100);
            default: write_reg(dae_pkg::CSR_MIN_INTERVAL, 31'($urandom_range(0, 400)));
         endcase
         case ($urandom_range(0, 3))
            0: write_reg(dae_pkg::CSR_STILL_THR, 31'd0);
            1: write_reg(dae_pkg::CSR_STILL_THR, 31'h000F_FFFF);
            2: write_reg(dae_pkg::CSR_STILL_THR, 31'd500);
            default: write_reg(dae_pkg::CSR_STILL_THR, 31'($urandom_range(0, 30000)));
         endcase
         case ($urandom_range(0, 3))
            0: write_reg(dae_pkg::CSR_ACCEL_LIMIT, 31'd0);
            1: write_reg(dae_pkg::CSR_ACCEL_LIMIT, 31'h7FFF_FFFF);
            2: write_reg(dae_pkg::CSR_ACCEL_LIMIT, 31'd20000000);
            default: write_reg(dae_pkg::CSR_ACCEL_LIMIT, 31'($urandom()));
         endcase
         quiet_mode = (phase % 4 == 3);
         clock_ms = $urandom();
         walk = $urandom_range(1, 65535);
         phase_base = fed_items;
         while (fed_items - phase_base < PHASE_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
               clock_ms += $urandom_range(0, 300);
               d = '0;
            end else if (roll < 12) begin
               // Deliberately too soon after the previous sample, unless the minimum interval is zero.
               clock_ms += (cfg_min_gap == 0) ? 0 : $urandom_range(0, cfg_min_gap - 1);
               d = 16'($urandom_range(1, 65535));
            end else if (roll < 18) begin
               clock_ms = $urandom();
               d = 16'($urandom_range(0, 65535));
            end else if (roll < 28) begin
               clock_ms += 32'(cfg_min_gap) + $urandom_range(0, 300);
               walk = $urandom_range(1, 65535);
               d = 16'(walk);
            end else begin
               // Smooth motion: small steps around the current distance.
               clock_ms += 32'(cfg_min_gap) + $urandom_range(0, 200);
               walk += int'($urandom_range(0, 400)) - 200;
               if (walk < 1) walk = 1;
               if (walk > 65535) walk = 65535;
               d = 16'(walk);
            end
            if ($urandom_range(0, 63) == 0) drain_results(0);
            send_sample(clock_ms, d, WANT_MODEL, NO_MOTION);
         end
      end

      drain_results(SETTLE_CYCLES);
      $display("Sent %0d samples, %0d taken into the window; %0d motion results checked.",
               fed_items, taken_items, results_checked);
      $display("Register extremes were exercised up front, then %0d random setting phases.",
               PHASES);
      if (faults == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin : result_check
      motion_type  want;
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         stall = quiet_mode ? 0 : $urandom_range(0, 6);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_ready <= 1'b1;
         end
         do @(posedge clock); while (!rsp_valid);
         if (motion_q.size() == 0) begin
            $display("%0t: unexpected result: position %0d velocity %0d accel %0d", $time,
                     rsp_position_um, rsp_velocity_um_s, rsp_accel_um_s2);
            faults++;
         end else begin
            want = motion_q.pop_front();
            results_checked++;
            if (rsp_position_um !== want.pos) begin
               $display("%0t: position_um expected %0d, got %0d", $time, want.pos,
                        rsp_position_um);
               faults++;
            end
            if (rsp_velocity_um_s !== want.vel) begin
               $display("%0t: velocity_um_s expected %0d, got %0d", $time, want.vel,
                        rsp_velocity_um_s);
               faults++;
            end
            if (rsp_accel_um_s2 !== want.acc) begin
               $display("%0t: accel_um_s2 expected %0d, got %0d", $time, want.acc,
                        rsp_accel_um_s2);
               faults++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we || reset)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

endmodule
